// ----- hdl/dcb_pkg.sv -----
// ----------------------------------------------------------------------------
// dcb_pkg - shared definitions for the DC blocking filter
// Constants, defaults and the tag that travels with each sample word.
// ----------------------------------------------------------------------------
package dcb_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  // Channel index and pole coefficient widths are fixed by the interface.
  localparam int CHAN_BITS  = 3;
  localparam int COEF_BITS  = 24;
  localparam logic [COEF_BITS-1:0] COEF_RESET = 24'd16766239;

  // Depth of the queue between the front end and the arithmetic core.
  localparam int QUEUE_DEPTH = 2;

  // Classification of one word, worked out by the front end.
  typedef struct packed {
    logic                 clear;    // zero every history before filtering
    logic                 known;    // channel has history storage
    logic [CHAN_BITS-1:0] channel;
  } tag_t;

endpackage

// ----- hdl/dcb_front.sv -----
// ----------------------------------------------------------------------------
// dcb_front - input stage
// Registers each accepted word and classifies its channel before queueing.
// ----------------------------------------------------------------------------
module dcb_front #(
  parameter int CHANNELS    = dcb_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [dcb_pkg::CHAN_BITS-1:0] in_channel,
  input  logic                   in_clear,
  output logic                   push,
  input  logic                   push_ready,
  output logic [SAMPLE_BITS-1:0] push_sample,
  output dcb_pkg::tag_t          push_tag
);

  logic held;

  assign in_ready = !held || push_ready;
  assign push     = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      push_sample      <= in_sample;
      push_tag.channel <= in_channel;
      push_tag.known   <= (32'(in_channel) < CHANNELS);
      push_tag.clear   <= in_clear;
    end
  end

endmodule

// ----- hdl/dcb_queue.sv -----
// ----------------------------------------------------------------------------
// dcb_queue - short word queue
// Small register queue that lets the front end and the core stall apart.
// ----------------------------------------------------------------------------
module dcb_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = dcb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign wr_ready = (count < CNT_BITS'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = store[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/dcb_core.sv -----
// ----------------------------------------------------------------------------
// dcb_core - filter arithmetic and channel history
// One multiply-add per word against the channel history, then saturation.
// ----------------------------------------------------------------------------
module dcb_core #(
  parameter int CHANNELS    = dcb_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [dcb_pkg::COEF_BITS-1:0] cfg_coef,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  input  dcb_pkg::tag_t          q_tag,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample,
  output logic [dcb_pkg::CHAN_BITS-1:0] out_channel,
  output logic                   out_clipped
);

  localparam int CB       = dcb_pkg::COEF_BITS;
  localparam int HB       = SAMPLE_BITS + 2;     // history keeps two bits of headroom
  localparam int PW       = CB + HB + 1;         // signed product width
  localparam int FW       = PW - CB;             // rounded feedback width
  localparam int SW       = SAMPLE_BITS + 4;     // exact sum width
  localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (CB - 1);
  localparam logic signed [SW-1:0] HIST_MAX   = {{(SW-HB+1){1'b0}}, {(HB-1){1'b1}}};
  localparam logic signed [SW-1:0] HIST_MIN   = ~HIST_MAX;
  localparam logic signed [SW-1:0] SAMP_MAX   =
    {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMP_MIN   = ~SAMP_MAX;

  logic [CB-1:0]                  coef;
  logic signed [SAMPLE_BITS-1:0]  last_input  [CHANNELS];
  logic signed [HB-1:0]           last_output [CHANNELS];

  logic [IDX_BITS-1:0]            idx;
  logic                           pop;
  logic signed [SAMPLE_BITS-1:0]  x;
  logic signed [SAMPLE_BITS-1:0]  li;
  logic signed [HB-1:0]           lo;
  logic signed [CB:0]             coef_s;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           prod_rnd;
  logic signed [FW-1:0]           fb;
  logic signed [SW-1:0]           sum;
  logic signed [HB-1:0]           hist_next;
  logic [SAMPLE_BITS-1:0]         y_next;
  logic                           clip_next;

  assign idx     = IDX_BITS'(q_tag.channel);
  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // A clear in this word makes the history read as zero for it.
  assign x        = signed'(q_sample);
  assign li       = q_tag.clear ? '0 : last_input[idx];
  assign lo       = q_tag.clear ? '0 : last_output[idx];
  assign coef_s   = signed'({1'b0, coef});
  assign prod     = coef_s * lo;
  assign prod_rnd = prod + ROUND_HALF;
  assign fb       = prod_rnd[PW-1:CB];
  assign sum      = SW'(x) - SW'(li) + SW'(fb);

  always_comb begin
    if (sum > HIST_MAX) begin
      hist_next = HIST_MAX[HB-1:0];
    end else if (sum < HIST_MIN) begin
      hist_next = HIST_MIN[HB-1:0];
    end else begin
      hist_next = sum[HB-1:0];
    end

    clip_next = 1'b0;
    if (!q_tag.known) begin
      y_next = q_sample;
    end else if (sum > SAMP_MAX) begin
      y_next    = SAMP_MAX[SAMPLE_BITS-1:0];
      clip_next = 1'b1;
    end else if (sum < SAMP_MIN) begin
      y_next    = SAMP_MIN[SAMPLE_BITS-1:0];
      clip_next = 1'b1;
    end else begin
      y_next = sum[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= dcb_pkg::COEF_RESET;
    end else if (cfg_write) begin
      coef <= cfg_coef;
    end
  end

  // The channel in use takes its new history; with a clear, every other
  // channel is zeroed in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_input[i]  <= '0;
        last_output[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (q_tag.known && idx == IDX_BITS'(i)) begin
          last_input[i]  <= x;
          last_output[i] <= hist_next;
        end else if (q_tag.clear) begin
          last_input[i]  <= '0;
          last_output[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_sample  <= y_next;
      out_channel <= q_tag.channel;
      out_clipped <= clip_next;
    end
  end

endmodule

// ----- hdl/dc_blocking_filter.sv -----
// ----------------------------------------------------------------------------
// dc_blocking_filter - multichannel DC blocking high-pass filter
// y = x - x_prev + c * y_prev per channel, rounded, saturated and flagged.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Content
// s_axis    in         s_axis_tvalid/s_axis_tready   sample, channel, clear
// m_axis    out        m_axis_tvalid/m_axis_tready   filtered sample, channel, clip
// cfg       in         cfg_valid/cfg_ready           pole coefficient (Q0.24)
//
// One word is accepted every clock cycle in steady flow; a word passes the
// input register, then the queue and the output register, before it appears
// on m_axis. The rate is set by the multiply-add that closes the history loop
// of a channel combinationally, so consecutive words of the same channel
// follow each other without a gap. Reset clears every channel history and
// loads the default coefficient. A stall on m_axis backs up into the
// two-entry queue and then into the input register before s_axis_tready falls.
//
module dc_blocking_filter #(
  parameter int CHANNELS    = dcb_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,

  // Input words: tdata [SAMPLE_BITS-1:0] sample_in, zero padding above.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser [2:0] channel_in, [3] clear_history
  input  logic [dcb_pkg::CHAN_BITS:0]   s_axis_tuser,

  // Output words: tdata [SAMPLE_BITS-1:0] sample_out, zero padding above.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser [2:0] channel_out, [3] clipped
  output logic [dcb_pkg::CHAN_BITS:0]   m_axis_tuser,

  // Coefficient writes; to be issued only while the filter is idle.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcb_pkg::COEF_BITS-1:0] cfg_data
);

  localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CB         = dcb_pkg::CHAN_BITS;
  localparam int QUEUE_BITS = SAMPLE_BITS + $bits(dcb_pkg::tag_t);

  logic                   push;
  logic                   push_ready;
  logic [SAMPLE_BITS-1:0] push_sample;
  dcb_pkg::tag_t          push_tag;

  logic                   q_valid;
  logic                   q_ready;
  logic [QUEUE_BITS-1:0]  q_data;
  logic [SAMPLE_BITS-1:0] q_sample;
  dcb_pkg::tag_t          q_tag;

  logic [SAMPLE_BITS-1:0] out_sample;
  logic [CB-1:0]          out_channel;
  logic                   out_clipped;

  // The coefficient register is always free to take a write.
  assign cfg_ready = 1'b1;

  // Front end: registers the word and works out whether its channel has history.
  dcb_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_channel  (s_axis_tuser[CB-1:0]),
    .in_clear    (s_axis_tuser[CB]),
    .push        (push),
    .push_ready  (push_ready),
    .push_sample (push_sample),
    .push_tag    (push_tag)
  );

  // Queue between the front end and the arithmetic core.
  dcb_queue #(
    .WIDTH (QUEUE_BITS),
    .DEPTH (dcb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_data  ({push_tag, push_sample}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_sample = q_data[SAMPLE_BITS-1:0];
  assign q_tag    = q_data[QUEUE_BITS-1:SAMPLE_BITS];

  // Back end: history, multiply-add, saturation and the output register.
  dcb_core #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_coef    (cfg_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_sample    (q_sample),
    .q_tag       (q_tag),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_sample  (out_sample),
    .out_channel (out_channel),
    .out_clipped (out_clipped)
  );

  assign m_axis_tdata = DATA_BITS'(out_sample);
  assign m_axis_tuser = {out_clipped, out_channel};

  // A clipped word must sit exactly on one of the two rails.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_clipped) |->
      (out_sample == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
       out_sample == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("clipped word is not at a saturation rail");

  // A channel without history passes straight through and is never clipped.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (32'(out_channel) >= CHANNELS)) |-> !out_clipped)
    else $error("pass-through word flagged as clipped");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

  // With the output free, the core never holds back a queued word.
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && !m_axis_tvalid) |-> q_ready)
    else $error("core stalled with an empty output register");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the DC blocking filter
// Streams samples over several channels and coefficient settings through the
// filter and compares every filtered word with a predicted history model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CHANNELS    = dcb_pkg::CHANNELS_DEF;
  localparam int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF;
  localparam int CHAN_BITS   = dcb_pkg::CHAN_BITS;
  localparam int COEF_BITS   = dcb_pkg::COEF_BITS;
  localparam logic [COEF_BITS-1:0] COEF_RESET = dcb_pkg::COEF_RESET;
  localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int HIST_BITS   = SAMPLE_BITS + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  localparam logic [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0]   COEF_MAX = {COEF_BITS{1'b1}};
  localparam logic [COEF_BITS-1:0]   COEF_HALF = {1'b1, {(COEF_BITS-1){1'b0}}};

  // One filtered word as the filter should present it.
  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CHAN_BITS-1:0]   channel;
    logic                   clipped;
  } filtered_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of every channel history and of the pole
  // coefficient, predicts the filtered word for each accepted input word and
  // checks the filter's output words against those predictions in order.
  // --------------------------------------------------------------------------
  class filter_scoreboard;
    longint          last_input[CHANNELS];
    longint          last_output[CHANNELS];
    logic [COEF_BITS-1:0] coefficient;
    filtered_t       pending_outputs[$];
    int              mismatches;
    int              words_checked;
    int              words_clipped;
    int              clears_seen;

    function new();
      foreach (last_input[i]) begin
        last_input[i]  = 0;
        last_output[i] = 0;
      end
      coefficient   = COEF_RESET;
      mismatches    = 0;
      words_checked = 0;
      words_clipped = 0;
      clears_seen   = 0;
    endfunction

    function void set_coefficient(logic [COEF_BITS-1:0] value);
      coefficient = value;
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Clamp to a two's complement width and say whether the value changed.
    function longint clamp(longint v, int bits, output bit hit);
      longint hi;
      longint lo;
      hi  = (longint'(1) <<< (bits - 1)) - 1;
      lo  = -hi - 1;
      hit = 1'b1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      hit = 1'b0;
      return v;
    endfunction

    function void note_input(logic signed [SAMPLE_BITS-1:0] sample,
                             logic [CHAN_BITS-1:0] chan, logic clear);
      filtered_t word;
      longint    x;
      longint    prod;
      longint    feedback;
      longint    total;
      bit        hit;
      bit        hist_hit;
      x = sample;
      if (clear) begin
        clears_seen++;
        foreach (last_input[i]) begin
          last_input[i]  = 0;
          last_output[i] = 0;
        end
      end
      word.sample  = sample;
      word.channel = chan;
      word.clipped = 1'b0;
      // Channels without history pass straight through.
      if (chan < CHANNELS) begin
        prod     = longint'(coefficient) * last_output[chan];
        feedback = (prod + (longint'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS;
        total    = x - last_input[chan] + feedback;
        last_input[chan]  = x;
        last_output[chan] = clamp(total, HIST_BITS, hist_hit);
        word.sample  = SAMPLE_BITS'(clamp(total, SAMPLE_BITS, hit));
        word.clipped = hit;
      end
      pending_outputs.insert(pending_outputs.size(), word);
    endfunction

    task check_output(logic [DATA_BITS-1:0] data, logic [CHAN_BITS:0] user);
      filtered_t want;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("output word %h/%h with nothing expected", data, user));
        return;
      end
      want = pending_outputs.pop_front();
      words_checked++;
      if (want.clipped) words_clipped++;
      if (data !== DATA_BITS'(want.sample))
        report_mismatch($sformatf("sample_out %h, expected %h (channel %0d)",
                                  data, want.sample, want.channel));
      if (user[CHAN_BITS-1:0] !== want.channel)
        report_mismatch($sformatf("channel_out %0d, expected %0d",
                                  user[CHAN_BITS-1:0], want.channel));
      if (user[CHAN_BITS] !== want.clipped)
        report_mismatch($sformatf("clipped %b, expected %b (channel %0d)",
                                  user[CHAN_BITS], want.clipped, want.channel));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the signals towards the filter. Every input starts at a
  // known value; the bench then only changes them on rising edges.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_BITS-1:0]   s_axis_tdata  = '0;  // [23:0] sample_in
  logic [CHAN_BITS:0]     s_axis_tuser  = '0;  // [2:0] channel_in, [3] clear_history

  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0]   m_axis_tdata;        // [23:0] sample_out
  logic [CHAN_BITS:0]     m_axis_tuser;        // [2:0] channel_out, [3] clipped

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COEF_BITS-1:0]   cfg_data  = '0;

  // When set, neither side idles: a long stretch of back-to-back words.
  bit steady = 1'b0;

  int cycle_count = 0;
  int settings_used = 1;

  filter_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dc_blocking_filter #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Output side: check each word taken on this edge, then choose whether to
  // stall on the next one. About 15 percent of the choices are stalls unless
  // the bench is in a steady stretch.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_output(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= steady || ($urandom_range(99) >= 15);
  end

  // Watchdog: a run that cannot finish is a failure in its own right.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d words outstanding",
               cycle_count, sb.pending());
      $display("FAIL dc_blocking_filter");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Offer one input word, with a random number of idle cycles in front of
  // it, and note it with the scoreboard once the filter has taken it.
  task automatic send_word(input logic [SAMPLE_BITS-1:0] sample,
                           input logic [CHAN_BITS-1:0] chan, input logic clear);
    while (!steady && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_BITS'(sample);
    s_axis_tuser  <= {clear, chan};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(sample, chan, clear);
  endtask

  // Stop sending and hold off until every predicted word has come back.
  // Every input word yields an output word, so an empty scoreboard means the
  // filter has nothing left in flight.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The coefficient may only change while the filter is idle.
  task automatic write_coefficient(input logic [COEF_BITS-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_coefficient(value);
    settings_used++;
  endtask

  // Random sample with a bias towards the interesting corners: full-scale
  // values, near full scale, tiny values and a steady DC offset whose decay
  // exercises the feedback path.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] s;
    s = SAMPLE_BITS'($urandom);
    case ($urandom_range(9))
      4: begin
        s = $urandom_range(1) ? FULL_POS : FULL_NEG;
      end
      5: begin
        s = SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
      end
      6: begin
        s = SAMPLE_BITS'(24'h180000) + SAMPLE_BITS'($urandom_range(15));
      end
      7: begin
        s = ($urandom_range(1) ? FULL_POS : FULL_NEG) ^ SAMPLE_BITS'($urandom_range(255));
      end
      default: ;
    endcase
    return s;
  endfunction

  // A run of random words. Channels are either random or held for a burst so
  // that one channel's history is worked over several words in a row; a
  // history clear turns up now and then.
  task automatic run_random_phase(input int count);
    logic [CHAN_BITS-1:0] chan;
    int                   burst;
    burst = 0;
    chan  = '0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        chan  = CHAN_BITS'($urandom);
        burst = ($urandom_range(3) == 0) ? $urandom_range(12, 2) : 1;
      end
      burst--;
      send_word(pick_sample(), chan, $urandom_range(99) < 2);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset coefficient: zero, full scale on both
    // sides so that the output saturates negative and then positive, small
    // steps, alternating bit patterns, a held DC level, and history clears
    // both on the channel in use and on another one.
    send_word('0, 3'd0, 1'b0);
    send_word(FULL_POS, 3'd0, 1'b0);
    send_word(FULL_NEG, 3'd0, 1'b0);
    send_word(FULL_POS, 3'd0, 1'b0);
    send_word(FULL_NEG, 3'd1, 1'b0);
    send_word(FULL_POS, 3'd1, 1'b0);
    send_word(SAMPLE_BITS'(24'h000001), 3'd2, 1'b0);
    send_word(SAMPLE_BITS'(24'hFFFFFF), 3'd2, 1'b0);
    send_word(SAMPLE_BITS'(24'h555555), 3'd3, 1'b0);
    send_word(SAMPLE_BITS'(24'hAAAAAA), 3'd4, 1'b0);
    send_word(SAMPLE_BITS'(24'h123456), 3'd5, 1'b0);
    send_word(SAMPLE_BITS'(24'h400000), 3'd6, 1'b0);
    send_word(SAMPLE_BITS'(24'h400000), 3'd7, 1'b0);
    send_word(SAMPLE_BITS'(24'h400000), 3'd7, 1'b0);
    send_word(SAMPLE_BITS'(24'h400000), 3'd0, 1'b1);
    send_word(FULL_POS, 3'd7, 1'b1);

    // No feedback at all: the filter is a plain first difference.
    write_coefficient('0);
    send_word(FULL_POS, 3'd2, 1'b0);
    send_word(FULL_NEG, 3'd2, 1'b0);
    send_word('0, 3'd2, 1'b0);

    // Largest feedback: the history swings towards its headroom limit.
    write_coefficient(COEF_MAX);
    send_word(FULL_POS, 3'd3, 1'b0);
    send_word(FULL_NEG, 3'd3, 1'b0);
    send_word(FULL_POS, 3'd3, 1'b0);
    send_word(FULL_NEG, 3'd3, 1'b0);
    send_word('0, 3'd3, 1'b1);

    // Random traffic, one phase per coefficient setting. The phase at one
    // half, where rounding ties are common, runs without any idling.
    run_random_phase(285);

    write_coefficient('0);
    run_random_phase(285);

    write_coefficient(COEF_HALF);
    steady = 1'b1;
    run_random_phase(285);
    steady = 1'b0;

    write_coefficient(COEF_RESET);
    run_random_phase(285);

    write_coefficient(COEF_BITS'($urandom));
    run_random_phase(285);

    write_coefficient(COEF_MAX - COEF_BITS'($urandom_range(65535)));
    run_random_phase(285);

    // Let the last words come back and leave a few cycles for anything
    // stray to show up.
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d filtered words across %0d coefficient settings, %0d history clears.",
             sb.words_checked, settings_used, sb.clears_seen);
    $display("%0d words saturated; %0d mismatches, %0d words still outstanding.",
             sb.words_clipped, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS dc_blocking_filter");
    end else begin
      $display("FAIL dc_blocking_filter");
    end
    $finish;
  end

endmodule
